FILE: src/rprf_pkg.sv
// shared types and constants of the radio packet receive filter
// no dependencies; the front end, back end, core and testbench import it
package rprf_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int HDR_W        = 8 * HEADER_BYTES;
  localparam int COUNT_W      = 9;
  localparam int COUNT_MAX    = 511;
  localparam int CMD_DEPTH    = 2;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
  // reads that can wait in the command queue plus the one in the back end
  localparam int RD_CNT_W     = $clog2(CMD_DEPTH + 2);
  localparam int APB_ADDR_W   = 3;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_LEN_ERR      = 2'd1,
    ST_NOT_FOR_NODE = 2'd2,
    ST_DUPLICATE    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef enum logic {
    ACT_RX_BYTE = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  typedef enum logic {
    REG_NODE_ADDR  = 1'b0,
    REG_BCAST_ADDR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [HDR_W-1:0]   header;
    logic               bank;
    logic               unread;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [HDR_W-1:0]   header;
    logic [7:0]         payload;
    logic               unread;
    logic               last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rd_done_t;

endpackage

FILE: src/rprf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rprf_fifo.sv
// small first-in first-out queue in flip-flops, used for commands and results
// no dependencies
module rprf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = slot_q[rptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/rprf_front.sv
// front end: takes input items, assembles the header, writes payload bytes,
// classifies packets and queues status and read commands; uses rprf_pkg
module rprf_front #(
  parameter int PAYLOAD_CAP = 32,
  parameter int SEQ_INIT    = 0,
  parameter int ADDR_W      = $clog2(2 * PAYLOAD_CAP)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              action_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [7:0]        node_addr_i,
  input  logic [7:0]        bcast_addr_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output rprf_pkg::cmd_t    cmd_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  input  rprf_pkg::rd_done_t rd_done_i
);

  import rprf_pkg::*;

  logic [COUNT_W-1:0]  byte_count_q, byte_count_d;
  logic [HDR_W-1:0]    rx_header_q, rx_header_d;
  logic [HDR_W-1:0]    stored_header_q, stored_header_d;
  logic                stored_bank_q, stored_bank_d;
  logic [15:0]         seen_seq_q, seen_seq_d;
  logic                unread_q, unread_d;
  logic [RD_CNT_W-1:0] rd_cnt0_q, rd_cnt0_d, rd_cnt1_q, rd_cnt1_d;

  logic               accept, is_byte, is_read, in_hdr, keep, pkt_end;
  logic [COUNT_W-1:0] pay_idx, cnt_inc, cnt_pay;
  logic [HDR_W-1:0]   hdr_new;
  logic [7:0]         declared, new_len;
  logic               len_ok, dest_hit, dup;
  status_e            status;
  logic               other_busy;

  assign accept  = push_i & ~full_o;
  assign is_byte = accept && (action_e'(action_i) == ACT_RX_BYTE);
  assign is_read = accept && (action_e'(action_i) == ACT_READ);
  assign pkt_end = is_byte && last_byte_i;

  assign in_hdr   = (byte_count_q < COUNT_W'(HEADER_BYTES));
  assign declared = rx_header_q[7:0];
  assign pay_idx  = byte_count_q - COUNT_W'(HEADER_BYTES);
  assign keep     = !in_hdr && (pay_idx < {1'b0, declared})
                    && (pay_idx < COUNT_W'(PAYLOAD_CAP));
  assign hdr_new  = in_hdr ? {rx_header_q[HDR_W-9:0], data_byte_i} : rx_header_q;
  assign cnt_inc  = (byte_count_q == COUNT_W'(COUNT_MAX)) ? byte_count_q
                                                           : byte_count_q + COUNT_W'(1);

  // classification sees the header and count including this byte
  assign new_len  = hdr_new[7:0];
  assign cnt_pay  = cnt_inc - COUNT_W'(HEADER_BYTES);
  assign len_ok   = (cnt_inc >= COUNT_W'(HEADER_BYTES))
                    && ({1'b0, new_len} <= COUNT_W'(PAYLOAD_CAP))
                    && (cnt_pay >= {1'b0, new_len});
  assign dest_hit = (hdr_new[47:40] == node_addr_i) || (hdr_new[47:40] == bcast_addr_i);
  assign dup      = (hdr_new[31:16] == seen_seq_q)
                    && (hdr_new[39:32] == stored_header_q[39:32]);

  always_comb begin
    if (!len_ok) begin
      status = ST_LEN_ERR;
    end else if (!dest_hit) begin
      status = ST_NOT_FOR_NODE;
    end else if (dup) begin
      status = ST_DUPLICATE;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  // payload goes to the bank that is not stored; hold off while a read of it is pending
  assign other_busy = (stored_bank_q ? rd_cnt0_q : rd_cnt1_q) != '0;
  assign full_o     = cmd_full_i || (other_busy && !in_hdr);

  assign ram_we_o    = is_byte && keep;
  assign ram_waddr_o = stored_bank_q ? ADDR_W'(pay_idx) : ADDR_W'(pay_idx) + ADDR_W'(PAYLOAD_CAP);
  assign ram_wdata_o = data_byte_i;

  always_comb begin
    byte_count_d    = byte_count_q;
    rx_header_d     = rx_header_q;
    stored_header_d = stored_header_q;
    stored_bank_d   = stored_bank_q;
    seen_seq_d      = seen_seq_q;
    unread_d        = unread_q;
    cmd_push_o      = 1'b0;
    cmd_o.kind      = KIND_STATUS;
    cmd_o.status    = ST_ACCEPTED;
    cmd_o.header    = stored_header_q;
    cmd_o.bank      = stored_bank_q;
    cmd_o.unread    = unread_q;
    if (is_byte) begin
      if (last_byte_i) begin
        byte_count_d = '0;
        rx_header_d  = '0;
        cmd_push_o   = 1'b1;
        cmd_o.status = status;
        if (status == ST_ACCEPTED) begin
          stored_header_d = hdr_new;
          stored_bank_d   = ~stored_bank_q;
          seen_seq_d      = hdr_new[31:16];
          unread_d        = 1'b1;
          cmd_o.header    = hdr_new;
          cmd_o.unread    = 1'b1;
        end
      end else begin
        byte_count_d = cnt_inc;
        rx_header_d  = hdr_new;
      end
    end else if (is_read) begin
      unread_d   = 1'b0;
      cmd_push_o = 1'b1;
      cmd_o.kind = KIND_READ;
    end
  end

  always_comb begin
    rd_cnt0_d = rd_cnt0_q;
    rd_cnt1_d = rd_cnt1_q;
    if (is_read && !stored_bank_q) begin
      rd_cnt0_d = rd_cnt0_d + RD_CNT_W'(1);
    end
    if (is_read && stored_bank_q) begin
      rd_cnt1_d = rd_cnt1_d + RD_CNT_W'(1);
    end
    if (rd_done_i.valid && !rd_done_i.bank) begin
      rd_cnt0_d = rd_cnt0_d - RD_CNT_W'(1);
    end
    if (rd_done_i.valid && rd_done_i.bank) begin
      rd_cnt1_d = rd_cnt1_d - RD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q    <= '0;
      rx_header_q     <= '0;
      stored_header_q <= '0;
      stored_bank_q   <= 1'b0;
      seen_seq_q      <= 16'(SEQ_INIT - 1);
      unread_q        <= 1'b0;
      rd_cnt0_q       <= '0;
      rd_cnt1_q       <= '0;
    end else begin
      byte_count_q    <= byte_count_d;
      rx_header_q     <= rx_header_d;
      stored_header_q <= stored_header_d;
      stored_bank_q   <= stored_bank_d;
      seen_seq_q      <= seen_seq_d;
      unread_q        <= unread_d;
      rd_cnt0_q       <= rd_cnt0_d;
      rd_cnt1_q       <= rd_cnt1_d;
    end
  end

  a_no_write_under_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !other_busy)
    else $error("payload write into a bank with a pending read");

  a_count_cleared_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_end |=> (byte_count_q == '0) && (rx_header_q == '0))
    else $error("packet state not cleared after last byte");

endmodule

FILE: src/rprf_back.sv
// back end: runs queued commands, one result beat per cycle while the result queue has credit, reading payload
// bytes from the ram through one registered read stage; uses rprf_pkg
module rprf_back #(
  parameter int PAYLOAD_CAP = 32,
  parameter int ADDR_W      = $clog2(2 * PAYLOAD_CAP)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_empty_i,
  input  rprf_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic [ADDR_W-1:0]            ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i,
  input  logic [rprf_pkg::OUT_CNT_W-1:0] out_count_i,
  output logic                         res_push_o,
  output rprf_pkg::result_t            res_o,
  output rprf_pkg::rd_done_t           rd_done_o
);

  import rprf_pkg::*;

  localparam int BW = $clog2(PAYLOAD_CAP + 1);

  logic          cur_valid_q, cur_valid_d;
  cmd_t          cur_q;
  logic [BW-1:0] beat_q, beat_d;
  logic          s1_valid_q;
  logic          s1_use_ram_q;
  result_t       s1_res_q;

  logic [BW-1:0]        n_bytes;
  logic                 use_ram, is_last, credit, issue;
  logic [OUT_CNT_W:0]   in_flight;

  // beats of a read: declared length clipped to capacity, one beat when empty
  assign n_bytes = (cur_q.header[7:0] > 8'(PAYLOAD_CAP)) ? BW'(PAYLOAD_CAP)
                                                          : BW'(cur_q.header[7:0]);
  assign use_ram = (cur_q.kind == KIND_READ) && (beat_q < n_bytes);
  assign is_last = (cur_q.kind == KIND_STATUS) || (n_bytes == '0)
                   || (beat_q == n_bytes - BW'(1));

  // only issue when the result queue has room for everything in flight
  assign in_flight = (OUT_CNT_W + 1)'(out_count_i) + (OUT_CNT_W + 1)'(s1_valid_q);
  assign credit    = in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign issue     = cur_valid_q && credit;
  assign cmd_pop_o = !cmd_empty_i && (!cur_valid_q || (issue && is_last));

  assign ram_raddr_o = cur_q.bank ? ADDR_W'(beat_q) + ADDR_W'(PAYLOAD_CAP) : ADDR_W'(beat_q);

  assign rd_done_o.valid = issue && is_last && (cur_q.kind == KIND_READ);
  assign rd_done_o.bank  = cur_q.bank;

  always_comb begin
    cur_valid_d = cur_valid_q;
    beat_d      = beat_q;
    if (issue) begin
      if (is_last) begin
        cur_valid_d = 1'b0;
      end else begin
        beat_d = beat_q + BW'(1);
      end
    end
    if (cmd_pop_o) begin
      cur_valid_d = 1'b1;
      beat_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      beat_q      <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      beat_q      <= beat_d;
      s1_valid_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (issue) begin
      s1_use_ram_q     <= use_ram;
      s1_res_q.kind    <= cur_q.kind;
      s1_res_q.status  <= cur_q.status;
      s1_res_q.header  <= cur_q.header;
      s1_res_q.payload <= '0;
      s1_res_q.unread  <= cur_q.unread;
      s1_res_q.last    <= is_last;
    end
  end

  always_comb begin
    res_o = s1_res_q;
    if (s1_use_ram_q) begin
      res_o.payload = ram_rdata_i;
    end
  end
  assign res_push_o = s1_valid_q;

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (out_count_i < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_load_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> cur_valid_q && (beat_q == '0))
    else $error("command load did not restart the beat counter");

endmodule

FILE: src/radio_packet_receive_filter_core.sv
// receive filter for radio packets: sustains one input transfer per cycle while full is low.
// a status report reaches the result queue through the command queue, the back end command
// register and its read stage; a read yields max(1, min(length, PAYLOAD_CAP)) beats, one per
// cycle while the result queue has room, set by the back end beat counter and the payload ram
// read port. a payload byte waits while a read of the bank it would overwrite is still pending.
// reset is asynchronous: all control state clears at once, the ram is not cleared.
module radio_packet_receive_filter_core #(
  parameter int PAYLOAD_CAP = 32,
  parameter int SEQ_INIT    = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            result_kind_o,
  output logic [1:0]                      status_o,
  output logic [7:0]                      dest_addr_o,
  output logic [7:0]                      src_addr_o,
  output logic [15:0]                     seq_num_o,
  output logic [7:0]                      msg_type_o,
  output logic [5:0]                      payload_len_o,
  output logic [7:0]                      payload_byte_o,
  output logic                            was_unread_o,
  output logic                            last_result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rprf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import rprf_pkg::*;

  localparam int ADDR_W = $clog2(2 * PAYLOAD_CAP);

  logic [7:0] node_addr_q, bcast_addr_q;
  logic       cfg_wr;

  cmd_t     cmd_in, cmd_out;
  logic     cmd_push, cmd_pop, cmd_full, cmd_empty;
  rd_done_t rd_done;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  result_t              res_in, res_out;
  logic                 res_push, res_full;
  logic [OUT_CNT_W-1:0] out_count;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q  <= 8'd1;
      bcast_addr_q <= 8'd255;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_NODE_ADDR:  node_addr_q  <= pwdata[7:0];
        REG_BCAST_ADDR: bcast_addr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_NODE_ADDR:  prdata = {24'd0, node_addr_q};
      REG_BCAST_ADDR: prdata = {24'd0, bcast_addr_q};
      default:        prdata = '0;
    endcase
  end

  rprf_front #(
    .PAYLOAD_CAP (PAYLOAD_CAP),
    .SEQ_INIT    (SEQ_INIT),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .node_addr_i  (node_addr_q),
    .bcast_addr_i (bcast_addr_q),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .rd_done_i    (rd_done)
  );

  rprf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  rprf_ram #(
    .WIDTH (8),
    .DEPTH (2 * PAYLOAD_CAP)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rprf_back #(
    .PAYLOAD_CAP (PAYLOAD_CAP),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .rd_done_o   (rd_done)
  );

  rprf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign result_kind_o  = res_out.kind;
  assign status_o       = res_out.status;
  assign dest_addr_o    = res_out.header[47:40];
  assign src_addr_o     = res_out.header[39:32];
  assign seq_num_o      = res_out.header[31:16];
  assign msg_type_o     = res_out.header[15:8];
  assign payload_len_o  = res_out.header[5:0];
  assign payload_byte_o = res_out.payload;
  assign was_unread_o   = res_out.unread;
  assign last_result_o  = res_out.last;

  a_out_never_overflows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full |-> !res_push || pop)
    else $error("result transfer lost at a full queue");

endmodule

FILE: sim/tb_top.sv
// testbench for radio_packet_receive_filter_core: random and directed packet
// streams, reads and address register writes, checked against a shadow model
// depends on rprf_pkg and the core module
module tb_top;
  import rprf_pkg::*;

  localparam int PAYLOAD_CAP  = 32;
  localparam int SEQ_INIT     = 0;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT     = 14;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [15:0] seq;
    logic [7:0]  mtype;
    logic [5:0]  plen;
    logic [7:0]  pbyte;
    logic        unread;
    logic        last;
  } beat_t;

  // shadow of the filter: header assembly, payload banks, stored message
  class filter_shadow;
    logic [7:0]  node_addr  = 8'd1;
    logic [7:0]  bcast_addr = 8'd255;
    int unsigned rx_count   = 0;
    logic [47:0] rx_hdr     = '0;
    logic [47:0] stored_hdr = '0;
    logic [7:0]  bank_mem [2*PAYLOAD_CAP];
    logic        cur_bank   = 1'b0;
    logic [15:0] seen_seq   = 16'(SEQ_INIT - 1);
    logic        unread     = 1'b0;
    beat_t       due[$];
    int          errors     = 0;

    function void set_reg(reg_idx_e r, logic [7:0] v);
      case (r)
        REG_NODE_ADDR:  node_addr = v;
        REG_BCAST_ADDR: bcast_addr = v;
        default: ;
      endcase
    endfunction

    function beat_t make_beat(kind_e k, status_e s, logic [7:0] pb, logic u, logic l);
      beat_t bt;
      bt.kind   = k;
      bt.status = s;
      bt.dest   = stored_hdr[47:40];
      bt.src    = stored_hdr[39:32];
      bt.seq    = stored_hdr[31:16];
      bt.mtype  = stored_hdr[15:8];
      bt.plen   = stored_hdr[5:0];
      bt.pbyte  = pb;
      bt.unread = u;
      bt.last   = l;
      return bt;
    endfunction

    function void note_input(action_e a, logic [7:0] b, logic l);
      int         n;
      int         beats;
      int         kept;
      int         idx;
      logic       was;
      status_e    st;
      logic [7:0] declared;
      if (a == ACT_READ) begin
        n = int'(stored_hdr[7:0]);
        if (n > PAYLOAD_CAP) n = PAYLOAD_CAP;
        beats = (n == 0) ? 1 : n;
        was = unread;
        // status field reads as zero on read beats
        for (int k = 0; k < beats; k++) begin
          idx = int'(cur_bank) * PAYLOAD_CAP + k;
          due.push_back(make_beat(KIND_READ, ST_ACCEPTED, (k < n) ? bank_mem[idx] : 8'h00,
                                  was, k == beats - 1));
        end
        unread = 1'b0;
        return;
      end
      declared = rx_hdr[7:0];
      if (rx_count < HEADER_BYTES) begin
        rx_hdr = {rx_hdr[39:0], b};
      end else begin
        idx = int'(rx_count) - HEADER_BYTES;
        if (idx < int'(declared) && idx < PAYLOAD_CAP)
          bank_mem[int'(!cur_bank) * PAYLOAD_CAP + idx] = b;
      end
      if (rx_count < COUNT_MAX) rx_count++;
      if (!l) return;
      declared = rx_hdr[7:0];
      if (rx_count < HEADER_BYTES) begin
        st = ST_LEN_ERR;
      end else begin
        kept = int'(rx_count) - HEADER_BYTES;
        if (kept > int'(declared)) kept = int'(declared);
        if (kept > PAYLOAD_CAP) kept = PAYLOAD_CAP;
        if (kept != int'(declared))
          st = ST_LEN_ERR;
        else if (rx_hdr[47:40] != node_addr && rx_hdr[47:40] != bcast_addr)
          st = ST_NOT_FOR_NODE;
        else if (rx_hdr[31:16] == seen_seq && rx_hdr[39:32] == stored_hdr[39:32])
          st = ST_DUPLICATE;
        else
          st = ST_ACCEPTED;
      end
      if (st == ST_ACCEPTED) begin
        stored_hdr = rx_hdr;
        cur_bank   = !cur_bank;
        seen_seq   = rx_hdr[31:16];
        unread     = 1'b1;
      end
      rx_count = 0;
      rx_hdr   = '0;
      due.push_back(make_beat(KIND_STATUS, st, 8'h00, unread, 1'b1));
    endfunction

    function void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(beat_t got);
      beat_t want;
      if (due.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      check_field("result_kind", want.kind, got.kind);
      check_field("status", want.status, got.status);
      check_field("dest_addr", want.dest, got.dest);
      check_field("src_addr", want.src, got.src);
      check_field("seq_num", want.seq, got.seq);
      check_field("msg_type", want.mtype, got.mtype);
      check_field("payload_len", want.plen, got.plen);
      check_field("payload_byte", want.pbyte, got.pbyte);
      check_field("was_unread", want.unread, got.unread);
      check_field("last_result", want.last, got.last);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic        action_i    = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic        result_kind_o;
  logic [1:0]  status_o;
  logic [7:0]  dest_addr_o;
  logic [7:0]  src_addr_o;
  logic [15:0] seq_num_o;
  logic [7:0]  msg_type_o;
  logic [5:0]  payload_len_o;
  logic [7:0]  payload_byte_o;
  logic        was_unread_o;
  logic        last_result_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  radio_packet_receive_filter_core #(
    .PAYLOAD_CAP(PAYLOAD_CAP),
    .SEQ_INIT(SEQ_INIT)
  ) dut (.*);

  filter_shadow sb = new();

  logic        quiet    = 1'b0;
  logic        hold_req = 1'b0;
  int          sent_items = 0;
  int          stall_cycles = 0;
  logic [7:0]  cur_node  = 8'd1;
  logic [7:0]  cur_bcast = 8'd255;
  logic [7:0]  last_src  = 8'h00;
  logic [15:0] good_seq  = 16'h0000;
  logic [15:0] seq_ctr   = 16'h0100;
  beat_t       got;
  logic        busy;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // transfers are sampled before the edge updates anything
  always @(posedge clk_i) begin
    if (rst_ni) begin
      busy = 1'b0;
      if (push && !full) begin
        sb.note_input(action_e'(action_i), data_byte_i, last_byte_i);
        busy = 1'b1;
      end
      if (pop && !empty) begin
        got = {result_kind_o, status_o, dest_addr_o, src_addr_o, seq_num_o, msg_type_o,
               payload_len_o, payload_byte_o, was_unread_o, last_result_o};
        sb.check_result(got);
        busy = 1'b1;
      end
      if (busy) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // result side: random pops, with one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
    end
  end

  task automatic send_item(action_e a, logic [7:0] b, logic l);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    action_i    <= a;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (full);
    sent_items++;
  endtask

  task automatic send_short(int n);
    for (int i = 0; i < n; i++) send_item(ACT_RX_BYTE, 8'($urandom), i == n - 1);
  endtask

  // read_at inserts a read before byte read_at of the packet, -1 for none
  task automatic send_packet(logic [7:0] dest, logic [7:0] src, logic [15:0] seq,
                             logic [7:0] mtype, logic [7:0] declared, int npay, int read_at);
    logic [7:0] hdr [HEADER_BYTES];
    int         total;
    logic [7:0] b;
    hdr   = '{dest, src, seq[15:8], seq[7:0], mtype, declared};
    total = HEADER_BYTES + npay;
    for (int i = 0; i < total; i++) begin
      if (i == read_at) send_item(ACT_READ, 8'($urandom), 1'($urandom));
      b = (i < HEADER_BYTES) ? hdr[i] : 8'($urandom);
      send_item(ACT_RX_BYTE, b, i == total - 1);
    end
  endtask

  function automatic logic [7:0] pick_dest();
    int r;
    r = $urandom_range(99);
    if (r < 60) return cur_node;
    if (r < 85) return cur_bcast;
    return 8'($urandom);
  endfunction

  task automatic send_random_packet();
    int          r;
    int          len;
    int          npay;
    int          rd;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [15:0] seq;
    r = $urandom_range(99);
    if (r < 8) begin
      send_short($urandom_range(HEADER_BYTES - 1, 1));
      return;
    end
    if (r < 15) begin
      send_item(ACT_READ, 8'($urandom), 1'($urandom));
      return;
    end
    dest = pick_dest();
    src  = 8'($urandom);
    seq_ctr += ($urandom_range(99) < 10) ? 16'($urandom) : 16'd1;
    seq  = seq_ctr;
    if (r < 21) begin
      // declared length rarely matches what arrives
      len  = $urandom_range(255);
      npay = $urandom_range(12);
    end else if (r < 25) begin
      len  = $urandom_range(PAYLOAD_CAP + 8, PAYLOAD_CAP + 1);
      npay = len + $urandom_range(2);
    end else if (r < 31) begin
      // replay of the last good header, a duplicate if it is still stored
      dest = cur_node;
      src  = last_src;
      seq  = good_seq;
      len  = 0;
      npay = 0;
    end else begin
      len  = ($urandom_range(99) < 15) ? $urandom_range(PAYLOAD_CAP) : $urandom_range(8);
      npay = len + (($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0);
      last_src = src;
      good_seq = seq;
    end
    rd = ($urandom_range(99) < 15) ? $urandom_range(HEADER_BYTES + npay - 1, 1) : -1;
    send_packet(dest, src, seq, 8'($urandom), 8'(len), npay, rd);
  endtask

  task automatic reg_write(reg_idx_e r, logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {24'h000000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk_i);
  endtask

  // let every expected result drain, then give the pipeline time to go quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int phase_start;
    int phase_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_READ, 8'h00, 1'b0);              // nothing stored yet
    send_item(ACT_RX_BYTE, 8'h00, 1'b0);           // ends inside the header
    send_item(ACT_RX_BYTE, 8'hFF, 1'b1);
    send_packet(8'hFF, 8'hA5, 16'h0001, 8'h00, 8'd2, 3, 3);
    send_item(ACT_READ, 8'hFF, 1'b1);
    send_packet(8'h01, 8'hA5, 16'h0001, 8'hFF, 8'd0, 0, -1);
    send_packet(8'h02, 8'h00, 16'hFFFF, 8'h00, 8'd0, 0, -1);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin cur_node = 8'h00; cur_bcast = 8'h00; end
        1: begin cur_node = 8'hFF; cur_bcast = 8'hFF; end
        2: begin cur_node = 8'($urandom); cur_bcast = 8'($urandom); end
        default: begin cur_node = 8'h5A; cur_bcast = 8'hA5; end
      endcase
      reg_write(REG_NODE_ADDR, cur_node);
      reg_write(REG_BCAST_ADDR, cur_bcast);
      quiet = (p == 2);
      if (p == 1) begin
        // full-size message, then long reads while the result side holds off
        seq_ctr += 16'd1;
        send_packet(cur_node, 8'($urandom), seq_ctr, 8'($urandom), 8'(PAYLOAD_CAP),
                    PAYLOAD_CAP, -1);
        hold_req = 1'b1;
        repeat (4) send_item(ACT_READ, 8'($urandom), 1'($urandom));
        send_random_packet();
      end
      // the phase without idling runs longest
      phase_start = sent_items;
      phase_len   = (p == 2) ? 36 : 8;
      while (sent_items - phase_start < phase_len) begin
        send_random_packet();
      end
    end
    quiet = 1'b0;
    settle();

    if (sb.errors == 0 && sb.due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
